[rtl/srbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbd_pkg: shared types and constants of the subtitle RLE bitmap decoder
// Request kinds, command word between front and back, color coefficients.
// ----------------------------------------------------------------------------
package srbd_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam int unsigned DIM_W  = 12;
  localparam int unsigned RUN_W  = 14;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 72;

  // input request kinds (s_axis tuser)
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_RLE     = 2'd2;

  // configuration register indexes
  localparam logic CFG_OBJECT_WIDTH  = 1'b0;
  localparam logic CFG_OBJECT_HEIGHT = 1'b1;

  // flags byte fields
  localparam int unsigned FLAG_EXT_BIT   = 6;
  localparam int unsigned FLAG_COLOR_BIT = 7;

  // heights above this use BT.709
  localparam logic [DIM_W-1:0] HD_HEIGHT_LIMIT = 12'd576;

  // Q1.14 coefficients
  localparam logic [14:0] HD_R_CR = 15'd25801;
  localparam logic [14:0] HD_G_CB = 15'd3069;
  localparam logic [14:0] HD_G_CR = 15'd7669;
  localparam logic [14:0] HD_B_CB = 15'd30402;
  localparam logic [14:0] SD_R_CR = 15'd22970;
  localparam logic [14:0] SD_G_CB = 15'd5638;
  localparam logic [14:0] SD_G_CR = 15'd11700;
  localparam logic [14:0] SD_B_CB = 15'd29032;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PALETTE,
    CMD_RUN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [DIM_W-1:0] row;
    logic [RUN_W-1:0] run;
    logic [7:0]       index;   // color of a run, or palette slot
    logic [7:0]       luma;
    logic [7:0]       cr;
    logic [7:0]       cb;
    logic [7:0]       alpha;
  } cmd_t;

  // floor by 2^14, clamp to 0..255
  function automatic logic [7:0] clamp_channel(input logic signed [25:0] acc);
    logic [7:0] res;
    if (acc[25]) begin
      res = 8'd0;
    end else if (|acc[24:22]) begin
      res = 8'hFF;
    end else begin
      res = acc[21:14];
    end
    return res;
  endfunction

endpackage

[rtl/srbd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbd_front: request intake and RLE code parser
// Tracks the code phase and the current row, and emits one command per
// start, palette write or completed code into the queue.
// ----------------------------------------------------------------------------
module srbd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [7:0]                 entry_index_i,
  input  logic [7:0]                 luma_i,
  input  logic [7:0]                 chroma_red_i,
  input  logic [7:0]                 chroma_blue_i,
  input  logic [7:0]                 opacity_i,
  input  logic [srbd_pkg::DIM_W-1:0] obj_height_i,
  input  logic                       full_i,
  output logic                       push_o,
  output srbd_pkg::cmd_t             cmd_o
);
  import srbd_pkg::*;

  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_FLAGS = 2'd1;
  localparam logic [1:0] PH_EXT   = 2'd2;
  localparam logic [1:0] PH_COLOR = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic             color_next_q, color_next_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [DIM_W-1:0] row_q, row_d;

  logic             accept;
  logic             fin;
  logic [RUN_W-1:0] fin_run;
  logic [7:0]       fin_color;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    phase_d      = phase_q;
    color_next_d = color_next_q;
    run_d        = run_q;
    row_d        = row_q;
    fin          = 1'b0;
    fin_run      = run_q;
    fin_color    = data_byte_i;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_RUN;
    cmd_o.row    = row_q;
    cmd_o.run    = run_q;
    cmd_o.index  = data_byte_i;
    cmd_o.luma   = luma_i;
    cmd_o.cr     = chroma_red_i;
    cmd_o.cb     = chroma_blue_i;
    cmd_o.alpha  = opacity_i;

    if (accept) begin
      case (kind_i)
        KIND_START: begin
          push_o       = 1'b1;
          cmd_o.kind   = CMD_START;
          phase_d      = PH_CODE;
          color_next_d = 1'b0;
          run_d        = '0;
          row_d        = '0;
        end
        KIND_PALETTE: begin
          push_o      = 1'b1;
          cmd_o.kind  = CMD_PALETTE;
          cmd_o.index = entry_index_i;
        end
        KIND_RLE: begin
          // bytes past the last row are dropped, parser held
          if (row_q < obj_height_i) begin
            case (phase_q)
              PH_CODE: begin
                if (data_byte_i != 8'd0) begin
                  fin       = 1'b1;
                  fin_run   = RUN_W'(1);
                  fin_color = data_byte_i;
                end else begin
                  phase_d = PH_FLAGS;
                end
              end
              PH_FLAGS: begin
                run_d        = {8'd0, data_byte_i[5:0]};
                color_next_d = data_byte_i[FLAG_COLOR_BIT];
                if (data_byte_i[FLAG_EXT_BIT]) begin
                  phase_d = PH_EXT;
                end else if (data_byte_i[FLAG_COLOR_BIT]) begin
                  phase_d = PH_COLOR;
                end else begin
                  fin       = 1'b1;
                  fin_run   = {8'd0, data_byte_i[5:0]};
                  fin_color = 8'd0;
                end
              end
              PH_EXT: begin
                run_d = {run_q[5:0], data_byte_i};
                if (color_next_q) begin
                  phase_d = PH_COLOR;
                end else begin
                  fin       = 1'b1;
                  fin_run   = {run_q[5:0], data_byte_i};
                  fin_color = 8'd0;
                end
              end
              PH_COLOR: begin
                fin       = 1'b1;
                fin_run   = run_q;
                fin_color = data_byte_i;
              end
              default: begin
                phase_d = PH_CODE;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    if (fin) begin
      push_o       = 1'b1;
      cmd_o.kind   = CMD_RUN;
      cmd_o.run    = fin_run;
      cmd_o.index  = fin_color;
      phase_d      = PH_CODE;
      color_next_d = 1'b0;
      run_d        = '0;
      // zero run is a line end
      if (fin_run == '0) begin
        row_d = row_q + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_CODE;
      color_next_q <= 1'b0;
      run_q        <= '0;
      row_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      color_next_q <= color_next_d;
      run_q        <= run_d;
      row_q        <= row_d;
    end
  end

endmodule

[rtl/srbd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbd_queue: command queue between front and back
// Small register FIFO; head is read combinationally.
// ----------------------------------------------------------------------------
module srbd_queue #(
  parameter int unsigned DEPTH = srbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srbd_pkg::cmd_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output srbd_pkg::cmd_t head_o
);
  import srbd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/srbd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbd_back: command execution, palette and run output
// Stage A: column tracking, run clipping, chroma products.
// Stage B: palette write/clear or palette read into the output register.
// ----------------------------------------------------------------------------
module srbd_back #(
  parameter int unsigned PALETTE_DEPTH = srbd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  srbd_pkg::cmd_t             cmd_i,
  input  logic [srbd_pkg::DIM_W-1:0] obj_width_i,
  input  logic [srbd_pkg::DIM_W-1:0] obj_height_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [srbd_pkg::DIM_W-1:0] row_o,
  output logic [srbd_pkg::DIM_W-1:0] column_o,
  output logic [srbd_pkg::RUN_W-1:0] run_length_o,
  output logic [7:0]                 out_alpha_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic                       line_end_o
);
  import srbd_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  // stage A
  logic                    a_valid_q;
  cmd_kind_e               a_kind_q;
  logic [DIM_W-1:0]        a_row_q, a_col_q;
  logic [RUN_W-1:0]        a_run_q;
  logic                    a_le_q;
  logic [7:0]              a_index_q, a_luma_q, a_alpha_q;
  logic signed [24:0]      a_r_cr_q, a_g_cb_q, a_g_cr_q, a_b_cb_q;

  // output stage
  logic                    c_valid_q;
  logic [DIM_W-1:0]        c_row_q, c_col_q;
  logic [RUN_W-1:0]        c_run_q;
  logic                    c_le_q, c_hit_q;
  logic [31:0]             rdata_q;

  logic [31:0]             pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_valid_q;

  logic [DIM_W-1:0]        col_q, col_d;
  logic                    adv, pop, hd, line_end;
  logic [RUN_W:0]          run_end;
  logic [RUN_W-1:0]        clip_run;
  logic [14:0]             k_r_cr, k_g_cb, k_g_cr, k_b_cb;
  logic signed [8:0]       cr_c, cb_c;
  logic signed [25:0]      y_term, acc_r, acc_g, acc_b;
  logic [AW-1:0]           addr;
  logic                    in_range;
  logic [31:0]             argb;

  assign adv         = !c_valid_q || out_ready_i;
  assign cmd_ready_o = adv;
  assign pop         = adv && cmd_valid_i;

  // run clipping against the width
  assign line_end = (cmd_i.run == '0);
  assign run_end  = {{(RUN_W - DIM_W + 1){1'b0}}, col_q} + {1'b0, cmd_i.run};
  always_comb begin
    if (col_q >= obj_width_i) begin
      clip_run = '0;
    end else if (run_end > {{(RUN_W - DIM_W + 1){1'b0}}, obj_width_i}) begin
      clip_run = {{(RUN_W - DIM_W){1'b0}}, obj_width_i - col_q};
    end else begin
      clip_run = cmd_i.run;
    end
  end

  always_comb begin
    col_d = col_q;
    if (pop) begin
      case (cmd_i.kind)
        CMD_START: col_d = '0;
        CMD_RUN: begin
          if (line_end) begin
            col_d = '0;
          end else begin
            col_d = col_q + clip_run[DIM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // coefficient set and centered chroma
  assign hd     = (obj_height_i > HD_HEIGHT_LIMIT);
  assign k_r_cr = hd ? HD_R_CR : SD_R_CR;
  assign k_g_cb = hd ? HD_G_CB : SD_G_CB;
  assign k_g_cr = hd ? HD_G_CR : SD_G_CR;
  assign k_b_cb = hd ? HD_B_CB : SD_B_CB;
  assign cr_c   = $signed({1'b0, cmd_i.cr}) - 9'sd128;
  assign cb_c   = $signed({1'b0, cmd_i.cb}) - 9'sd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      col_q     <= '0;
    end else begin
      col_q <= col_d;
      if (adv) begin
        a_valid_q <= cmd_valid_i;
        c_valid_q <= a_valid_q && (a_kind_q == CMD_RUN);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_kind_q  <= cmd_i.kind;
      a_row_q   <= cmd_i.row;
      a_col_q   <= line_end ? '0 : col_q;
      a_run_q   <= line_end ? '0 : clip_run;
      a_le_q    <= line_end;
      a_index_q <= cmd_i.index;
      a_luma_q  <= cmd_i.luma;
      a_alpha_q <= cmd_i.alpha;
      a_r_cr_q  <= $signed({1'b0, k_r_cr}) * cr_c;
      a_g_cb_q  <= $signed({1'b0, k_g_cb}) * cb_c;
      a_g_cr_q  <= $signed({1'b0, k_g_cr}) * cr_c;
      a_b_cb_q  <= $signed({1'b0, k_b_cb}) * cb_c;
    end
  end

  // palette conversion sums
  assign y_term = $signed({4'd0, a_luma_q, 14'd0});
  assign acc_r  = y_term + a_r_cr_q;
  assign acc_g  = y_term - a_g_cb_q - a_g_cr_q;
  assign acc_b  = y_term + a_b_cb_q;
  assign argb   = {a_alpha_q, clamp_channel(acc_r), clamp_channel(acc_g),
                   clamp_channel(acc_b)};

  assign addr     = a_index_q[AW-1:0];
  assign in_range = (int'(a_index_q) < PALETTE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (adv && a_valid_q) begin
      if (a_kind_q == CMD_PALETTE && in_range) begin
        pal_mem[addr] <= argb;
      end
      if (a_kind_q == CMD_RUN) begin
        rdata_q <= pal_mem[addr];
        c_row_q <= a_row_q;
        c_col_q <= a_col_q;
        c_run_q <= a_run_q;
        c_le_q  <= a_le_q;
        c_hit_q <= !a_le_q && in_range && pal_valid_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q <= '0;
    end else if (adv && a_valid_q) begin
      if (a_kind_q == CMD_START) begin
        pal_valid_q <= '0;
      end else if (a_kind_q == CMD_PALETTE && in_range) begin
        pal_valid_q[addr] <= 1'b1;
      end
    end
  end

  assign out_valid_o  = c_valid_q;
  assign row_o        = c_row_q;
  assign column_o     = c_col_q;
  assign run_length_o = c_run_q;
  assign line_end_o   = c_le_q;
  assign out_alpha_o  = c_hit_q ? rdata_q[31:24] : 8'd0;
  assign red_o        = c_hit_q ? rdata_q[23:16] : 8'd0;
  assign green_o      = c_hit_q ? rdata_q[15:8]  : 8'd0;
  assign blue_o       = c_hit_q ? rdata_q[7:0]   : 8'd0;

endmodule

[rtl/subtitle_rle_bitmap_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_rle_bitmap_decoder: run-length subtitle bitmap decoder
// Input requests on s_axis (tuser gives the kind: start, palette write,
// RLE byte). Each completed code leaves as one m_axis request: a pixel
// run with its RGBA color, or a line end (tuser set).
// One input request per cycle is accepted while the command queue has
// room. A request that completes a code passes the queue entry, the
// clip-and-multiply register and the palette access stage register,
// whose RAM read is registered, before it shows on m_axis. Sustained
// throughput is one request per cycle while m_axis is ready. When m_axis
// stalls the back stages hold and the queue fills; s_axis tready drops
// only once the queue is full. Object width and height are to be written
// on the cfg port only while idle; the block does not enforce this. Height
// selects BT.709 above 576 rows. Reset clears parser, position, palette
// valid bits and both size registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module subtitle_rle_bitmap_decoder #(
  parameter int unsigned PALETTE_DEPTH = srbd_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH   = srbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // data_byte, entry_index, luma, chroma_red, chroma_blue, opacity
  input  logic [srbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // row, column, run_length, out_alpha, red, green, blue, zero pad
  output logic [srbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // line_end
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [srbd_pkg::DIM_W-1:0]       cfg_data_i
);
  import srbd_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic             push, full, q_valid, q_pop;
  cmd_t             push_cmd, head_cmd;
  logic [DIM_W-1:0] row, column;
  logic [RUN_W-1:0] run_length;
  logic [7:0]       out_alpha, red, green, blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OBJECT_WIDTH:  width_q  <= cfg_data_i;
        CFG_OBJECT_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .kind_i        (s_axis_tuser),
    .data_byte_i   (s_axis_tdata[7:0]),
    .entry_index_i (s_axis_tdata[15:8]),
    .luma_i        (s_axis_tdata[23:16]),
    .chroma_red_i  (s_axis_tdata[31:24]),
    .chroma_blue_i (s_axis_tdata[39:32]),
    .opacity_i     (s_axis_tdata[47:40]),
    .obj_height_i  (height_q),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  srbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .head_o      (head_cmd)
  );

  srbd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_pop),
    .cmd_i        (head_cmd),
    .obj_width_i  (width_q),
    .obj_height_i (height_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .row_o        (row),
    .column_o     (column),
    .run_length_o (run_length),
    .out_alpha_o  (out_alpha),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue),
    .line_end_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, blue, green, red, out_alpha, run_length, column, row};

endmodule
